[hw/rtl/csf_pkg.sv]
package csf_pkg;

  localparam int unsigned FixW   = 48;
  localparam int unsigned CountW = 32;
  localparam int unsigned RootW  = 32;
  localparam int unsigned FracW  = 16;
  localparam int unsigned SqInW  = 2 * RootW;

  localparam logic [CountW-1:0] OneObs   = CountW'(1);
  localparam logic [FixW-1:0]   MaxPos   = {1'b0, {(FixW-1){1'b1}}};
  localparam logic [FixW-1:0]   MinNegMg = {1'b1, {(FixW-1){1'b0}}};

  typedef struct packed {
    logic signed [FixW-1:0] column_sum;
    logic [FixW-1:0]        column_sum_squares;
    logic [FixW-1:0]        column_centered_squares;
    logic                   last_column;
  } in_item_t;

  typedef struct packed {
    logic signed [FixW-1:0] mean_value;
    logic [FixW-1:0]        variance_value;
    logic [FixW-1:0]        raw_moment_value;
    logic [RootW-1:0]       stddev_value;
    logic signed [FixW-1:0] variation_value;
    logic                   mean_invalid;
    logic                   variance_invalid;
    logic                   variation_invalid;
    logic                   last_out;
  } out_item_t;

  // carried alongside the square root
  typedef struct packed {
    logic [FixW-1:0] mean_mag;
    logic [FixW-1:0] mean_bits;
    logic [FixW-1:0] variance;
    logic [FixW-1:0] raw_moment;
    logic            sum_neg;
    logic            mean_inv;
    logic            var_inv;
    logic            last;
  } sq_side_t;

  // carried alongside the variation divide
  typedef struct packed {
    logic [FixW-1:0]  mean_bits;
    logic [FixW-1:0]  variance;
    logic [FixW-1:0]  raw_moment;
    logic [RootW-1:0] stddev;
    logic             sum_neg;
    logic             mean_inv;
    logic             var_inv;
    logic             vari_inv;
    logic             last;
  } vd_side_t;

endpackage

[hw/rtl/column_statistics_finalize.sv]
// Column statistics finalizer.
// Input channel (in_valid_i / in_stall_o / in_item_i): one item per column
// holding the sum, sum of squares and centred sum of squares in Q.16.
// Output channel (out_valid_o / out_stall_i / out_item_o): one item per
// input item with mean, unbiased variance, raw second moment, standard
// deviation, coefficient of variation, three invalid flags and last_out.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): the observation
// count n; always ready; write it only while the pipeline is empty.
// The pipeline has 48 divider stages (three dividers in parallel for
// sum/n, squares/n and centred/(n-1)), 32 square-root stages, 48 stages
// for stddev/mean and one output register. One item a cycle is accepted
// while the output is not stalled; only the output side limits it.
// A stall from the receiver freezes the whole pipeline while a result is
// waiting, so in_stall_o follows it; bubbles inside keep moving otherwise.
// Reset empties the pipeline and sets n back to 1.
module column_statistics_finalize (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  csf_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output csf_pkg::out_item_t               out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [csf_pkg::CountW-1:0]       cfg_data_i
);
  import csf_pkg::*;

  logic [CountW-1:0] n_q;
  logic              en;

  // config register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= OneObs;
    end else if (cfg_valid_i) begin
      n_q <= cfg_data_i;
    end
  end

  // pipeline advances unless a finished item is held up
  logic out_valid_q;
  assign en          = ~(out_valid_q & out_stall_i);
  assign in_stall_o  = ~en;
  assign out_valid_o = out_valid_q;

  // entry: sign/magnitude split
  logic            sum_neg, mean_inv, var_inv;
  logic [FixW-1:0] sum_mag;
  always_comb begin
    sum_neg  = in_item_i.column_sum[FixW-1];
    sum_mag  = sum_neg ? (~in_item_i.column_sum + FixW'(1)) : in_item_i.column_sum;
    mean_inv = (n_q == '0);
    var_inv  = (n_q < 2);
  end

  logic            v_mean, v_raw, v_var;
  logic [FixW-1:0] q_mean, q_raw, q_var;
  logic [1:0]      s_mean;
  logic            s_raw, s_var;

  csf_div #(.NUM_W(FixW), .DEN_W(CountW), .SIDE_W(2)) u_div_mean (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .num_i(sum_mag), .den_i(n_q), .side_i({sum_neg, mean_inv}),
    .valid_o(v_mean), .quo_o(q_mean), .side_o(s_mean)
  );

  csf_div #(.NUM_W(FixW), .DEN_W(CountW), .SIDE_W(1)) u_div_raw (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .num_i(in_item_i.column_sum_squares), .den_i(n_q),
    .side_i(in_item_i.last_column),
    .valid_o(v_raw), .quo_o(q_raw), .side_o(s_raw)
  );

  csf_div #(.NUM_W(FixW), .DEN_W(CountW), .SIDE_W(1)) u_div_var (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .num_i(in_item_i.column_centered_squares), .den_i(n_q - OneObs),
    .side_i(var_inv),
    .valid_o(v_var), .quo_o(q_var), .side_o(s_var)
  );

  // after the first dividers: clear the meaningless quotients
  sq_side_t        sq_in, sq_out;
  logic            v_sq;
  logic [RootW-1:0] root;
  always_comb begin
    sq_in.sum_neg    = s_mean[1];
    sq_in.mean_inv   = s_mean[0];
    sq_in.var_inv    = s_var;
    sq_in.last       = s_raw;
    sq_in.mean_mag   = s_mean[0] ? '0 : q_mean;
    sq_in.raw_moment = s_mean[0] ? '0 : q_raw;
    sq_in.variance   = s_var ? '0 : q_var;
    sq_in.mean_bits  = s_mean[1] ? (~sq_in.mean_mag + FixW'(1)) : sq_in.mean_mag;
  end

  csf_sqrt #(.SIDE_W($bits(sq_side_t))) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_mean & v_raw & v_var),
    .x_i({sq_in.variance, FracW'(0)}), .side_i(sq_in),
    .valid_o(v_sq), .root_o(root), .side_o(sq_out)
  );

  // variation = stddev * 2^16 / |mean|
  vd_side_t        vd_in, vd_out;
  logic            v_vd;
  logic [FixW-1:0] q_vd;
  always_comb begin
    vd_in.mean_bits  = sq_out.mean_bits;
    vd_in.variance   = sq_out.variance;
    vd_in.raw_moment = sq_out.raw_moment;
    vd_in.stddev     = root;
    vd_in.sum_neg    = sq_out.sum_neg;
    vd_in.mean_inv   = sq_out.mean_inv;
    vd_in.var_inv    = sq_out.var_inv;
    vd_in.vari_inv   = sq_out.var_inv | (sq_out.mean_mag == '0);
    vd_in.last       = sq_out.last;
  end

  csf_div #(.NUM_W(FixW), .DEN_W(FixW), .SIDE_W($bits(vd_side_t))) u_div_vari (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_sq),
    .num_i({root, FracW'(0)}), .den_i(sq_out.mean_mag), .side_i(vd_in),
    .valid_o(v_vd), .quo_o(q_vd), .side_o(vd_out)
  );

  // saturate, negate, register the result
  out_item_t       out_d, out_q;
  logic [FixW-1:0] q_sat;
  always_comb begin
    if (vd_out.sum_neg) begin
      q_sat = (q_vd > MinNegMg) ? MinNegMg : q_vd;
      q_sat = ~q_sat + FixW'(1);
    end else begin
      q_sat = (q_vd > MaxPos) ? MaxPos : q_vd;
    end
    out_d.mean_value        = vd_out.mean_bits;
    out_d.variance_value    = vd_out.variance;
    out_d.raw_moment_value  = vd_out.raw_moment;
    out_d.stddev_value      = vd_out.stddev;
    out_d.variation_value   = vd_out.vari_inv ? '0 : q_sat;
    out_d.mean_invalid      = vd_out.mean_inv;
    out_d.variance_invalid  = vd_out.var_inv;
    out_d.variation_invalid = vd_out.vari_inv;
    out_d.last_out          = vd_out.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_item_o = out_q;

endmodule

[hw/rtl/csf_div.sv]
// Restoring divider, one quotient bit per register stage.
module csf_div #(
  parameter int unsigned NUM_W  = 48,
  parameter int unsigned DEN_W  = 32,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [NUM_W-1:0]  nq   [NUM_W+1];
  logic [DEN_W-1:0]  rem  [NUM_W+1];
  logic [DEN_W-1:0]  den  [NUM_W+1];
  logic [SIDE_W-1:0] side [NUM_W+1];
  logic              vld  [NUM_W+1];

  assign nq[0]   = num_i;
  assign rem[0]  = '0;
  assign den[0]  = den_i;
  assign side[0] = side_i;
  assign vld[0]  = valid_i;

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W:0]    trial, diff;
    logic              ge;
    logic [NUM_W-1:0]  nq_q;
    logic [DEN_W-1:0]  rem_q, den_q;
    logic [SIDE_W-1:0] side_q;
    logic              vld_q;

    always_comb begin
      trial = {rem[s], nq[s][NUM_W-1]};
      diff  = trial - {1'b0, den[s]};
      ge    = ~diff[DEN_W];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q   <= {nq[s][NUM_W-2:0], ge};
        rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_q  <= den[s];
        side_q <= side[s];
      end
    end

    assign nq[s+1]   = nq_q;
    assign rem[s+1]  = rem_q;
    assign den[s+1]  = den_q;
    assign side[s+1] = side_q;
    assign vld[s+1]  = vld_q;
  end

  assign valid_o = vld[NUM_W];
  assign quo_o   = nq[NUM_W];
  assign side_o  = side[NUM_W];

endmodule

[hw/rtl/csf_sqrt.sv]
// Floor square root, one root bit per register stage.
module csf_sqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [csf_pkg::SqInW-1:0] x_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     valid_o,
  output logic [csf_pkg::RootW-1:0] root_o,
  output logic [SIDE_W-1:0]        side_o
);
  import csf_pkg::*;

  localparam int unsigned RemW = RootW + 3;

  logic [SqInW-1:0]  xs   [RootW+1];
  logic [RootW-1:0]  root [RootW+1];
  logic [RemW-1:0]   rem  [RootW+1];
  logic [SIDE_W-1:0] side [RootW+1];
  logic              vld  [RootW+1];

  assign xs[0]   = x_i;
  assign root[0] = '0;
  assign rem[0]  = '0;
  assign side[0] = side_i;
  assign vld[0]  = valid_i;

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    logic [RemW-1:0]   trial_rem, trial, diff;
    logic              ge;
    logic [SqInW-1:0]  x_q;
    logic [RootW-1:0]  root_q;
    logic [RemW-1:0]   rem_q;
    logic [SIDE_W-1:0] side_q;
    logic              vld_q;

    always_comb begin
      trial_rem = {rem[s][RemW-3:0], xs[s][SqInW-1 -: 2]};
      trial     = {1'b0, root[s], 2'b01};
      diff      = trial_rem - trial;
      ge        = trial_rem >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q    <= {xs[s][SqInW-3:0], 2'b00};
        root_q <= {root[s][RootW-2:0], ge};
        rem_q  <= ge ? diff : trial_rem;
        side_q <= side[s];
      end
    end

    assign xs[s+1]   = x_q;
    assign root[s+1] = root_q;
    assign rem[s+1]  = rem_q;
    assign side[s+1] = side_q;
    assign vld[s+1]  = vld_q;
  end

  assign valid_o = vld[RootW];
  assign root_o  = root[RootW];
  assign side_o  = side[RootW];

endmodule
